[sv/ycu_pkg.sv]
// Shared types, widths and conversion constants for the YCbCr upsampler.
package ycu_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 512;

    localparam int ADDR_W      = 16;
    localparam int BANK_ADDR_W = ADDR_W - 1;
    localparam int BANK_DEPTH  = 1 << BANK_ADDR_W;
    localparam int ENTRY_W     = 16;
    localparam int PIX_W       = 8;
    localparam int X_W         = 10;
    localparam int Y_W         = 9;
    localparam int FW_W        = 11;
    localparam int FH_W        = 10;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CCOL_W      = 9;
    localparam int COEF_W      = 18;
    localparam int PROD_W      = COEF_W + PIX_W;
    localparam int SUM_W       = 28;
    localparam int FRAC_W      = 16;

    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [BANK_ADDR_W-1:0] baddr_t;
    typedef logic [ENTRY_W-1:0]     entry_t;
    typedef logic [PIX_W-1:0]       pix_t;
    typedef logic [CCOL_W-1:0]      ccnt_t;
    typedef logic [COEF_W-1:0]      coef_t;
    typedef logic [PROD_W-1:0]      prod_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 10'd512;

    localparam coef_t K_Y    = 18'd76309;
    localparam coef_t K_R_CR = 18'd104597;
    localparam coef_t K_G_CB = 18'd25674;
    localparam coef_t K_G_CR = 18'd53279;
    localparam coef_t K_B_CB = 18'd132201;

    localparam sum_t OFF_R = 28'sd14609351;
    localparam sum_t OFF_G = 28'sd8885109;
    localparam sum_t OFF_B = 28'sd18142724;

    typedef struct packed {
        logic       sel_top;
        logic       sel_bot;
        logic       clamp_x;
        logic [1:0] sub_x;
        logic       sub_y;
    } interp_ctl_t;

endpackage

[sv/ycu_bank.sv]
// One parity bank of the chroma store: one write port, two registered read ports.
module ycu_bank (
    input  logic            aclk,
    input  logic            we,
    input  ycu_pkg::baddr_t waddr,
    input  ycu_pkg::entry_t wdata,
    input  logic            re,
    input  ycu_pkg::baddr_t raddr_a,
    input  ycu_pkg::baddr_t raddr_b,
    output ycu_pkg::entry_t rdata_a,
    output ycu_pkg::entry_t rdata_b
);

    ycu_pkg::entry_t mem [ycu_pkg::BANK_DEPTH];
    ycu_pkg::entry_t rdata_a_reg;
    ycu_pkg::entry_t rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

[sv/ycu_interp.sv]
// Neighbor selection and bilinear chroma blend, registered Cb and Cr.
module ycu_interp (
    input  logic                 aclk,
    input  logic                 en,
    input  ycu_pkg::interp_ctl_t ctl,
    input  ycu_pkg::entry_t      even_top,
    input  ycu_pkg::entry_t      odd_top,
    input  ycu_pkg::entry_t      even_bot,
    input  ycu_pkg::entry_t      odd_bot,
    output ycu_pkg::pix_t        cb,
    output ycu_pkg::pix_t        cr
);

    function automatic ycu_pkg::pix_t blend(
        input ycu_pkg::pix_t p00,
        input ycu_pkg::pix_t p01,
        input ycu_pkg::pix_t p10,
        input ycu_pkg::pix_t p11,
        input logic [1:0]    sx,
        input logic          ty
    );
        logic [9:0]  wl;
        logic [9:0]  wr;
        logic [9:0]  h0;
        logic [9:0]  h1;
        logic [10:0] total;
        wl    = 10'd4 - {8'b0, sx};
        wr    = {8'b0, sx};
        h0    = {2'b0, p00} * wl + {2'b0, p01} * wr;
        h1    = {2'b0, p10} * wl + {2'b0, p11} * wr;
        total = ty ? ({1'b0, h0} + {1'b0, h1}) : {h0, 1'b0};
        return total[10:3];
    endfunction

    ycu_pkg::entry_t e00, e01, e10, e11;
    ycu_pkg::pix_t   cb_reg, cb_next;
    ycu_pkg::pix_t   cr_reg, cr_next;

    assign e00 = ctl.sel_top ? odd_top : even_top;
    assign e01 = ctl.clamp_x ? e00 : (ctl.sel_top ? even_top : odd_top);
    assign e10 = ctl.sel_bot ? odd_bot : even_bot;
    assign e11 = ctl.clamp_x ? e10 : (ctl.sel_bot ? even_bot : odd_bot);

    always_comb begin
        cb_next = blend(e00[7:0], e01[7:0], e10[7:0], e11[7:0], ctl.sub_x, ctl.sub_y);
        cr_next = blend(e00[15:8], e01[15:8], e10[15:8], e11[15:8], ctl.sub_x, ctl.sub_y);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cb_reg <= cb_next;
            cr_reg <= cr_next;
        end
    end

    assign cb = cb_reg;
    assign cr = cr_reg;

endmodule

[sv/ycu_csc.sv]
// BT.601 color conversion: registered products, then sum, clamp and output register.
module ycu_csc (
    input  logic          aclk,
    input  logic          en_prod,
    input  logic          en_out,
    input  ycu_pkg::pix_t luma,
    input  ycu_pkg::pix_t cb,
    input  ycu_pkg::pix_t cr,
    input  logic          oor,
    output ycu_pkg::pix_t red,
    output ycu_pkg::pix_t green,
    output ycu_pkg::pix_t blue,
    output logic          out_of_range
);

    function automatic ycu_pkg::pix_t clamp_byte(input ycu_pkg::sum_t v);
        logic [ycu_pkg::SUM_W-ycu_pkg::FRAC_W-1:0] q;
        ycu_pkg::pix_t                             res;
        q = v[ycu_pkg::SUM_W-1:ycu_pkg::FRAC_W];
        if (v[ycu_pkg::SUM_W-1]) begin
            res = '0;
        end else if (q > 12'd255) begin
            res = 8'd255;
        end else begin
            res = q[7:0];
        end
        return res;
    endfunction

    ycu_pkg::prod_t y_prod_reg, r_cr_prod_reg, g_cb_prod_reg, g_cr_prod_reg, b_cb_prod_reg;
    logic           oor_reg;
    ycu_pkg::sum_t  red_sum, green_sum, blue_sum;
    ycu_pkg::pix_t  red_reg, red_next;
    ycu_pkg::pix_t  green_reg, green_next;
    ycu_pkg::pix_t  blue_reg, blue_next;
    logic           out_oor_reg, out_oor_next;

    always_ff @(posedge aclk) begin
        if (en_prod) begin
            y_prod_reg    <= ycu_pkg::prod_t'(ycu_pkg::K_Y) * ycu_pkg::prod_t'(luma);
            r_cr_prod_reg <= ycu_pkg::prod_t'(ycu_pkg::K_R_CR) * ycu_pkg::prod_t'(cr);
            g_cb_prod_reg <= ycu_pkg::prod_t'(ycu_pkg::K_G_CB) * ycu_pkg::prod_t'(cb);
            g_cr_prod_reg <= ycu_pkg::prod_t'(ycu_pkg::K_G_CR) * ycu_pkg::prod_t'(cr);
            b_cb_prod_reg <= ycu_pkg::prod_t'(ycu_pkg::K_B_CB) * ycu_pkg::prod_t'(cb);
            oor_reg       <= oor;
        end
    end

    always_comb begin
        red_sum   = ycu_pkg::sum_t'(y_prod_reg) + ycu_pkg::sum_t'(r_cr_prod_reg)
                    - ycu_pkg::OFF_R;
        green_sum = ycu_pkg::sum_t'(y_prod_reg) - ycu_pkg::sum_t'(g_cb_prod_reg)
                    - ycu_pkg::sum_t'(g_cr_prod_reg) + ycu_pkg::OFF_G;
        blue_sum  = ycu_pkg::sum_t'(y_prod_reg) + ycu_pkg::sum_t'(b_cb_prod_reg)
                    - ycu_pkg::OFF_B;
        red_next     = oor_reg ? '0 : clamp_byte(red_sum);
        green_next   = oor_reg ? '0 : clamp_byte(green_sum);
        blue_next    = oor_reg ? '0 : clamp_byte(blue_sum);
        out_oor_next = oor_reg;
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            red_reg     <= red_next;
            green_reg   <= green_next;
            blue_reg    <= blue_next;
            out_oor_reg <= out_oor_next;
        end
    end

    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign out_of_range = out_oor_reg;

endmodule

[sv/ycbcr_upsample_to_rgb_unit.sv]
// Top level of the YCbCr to RGB converter with bilinear chroma upsampling.
//
// Usage: the s_ channel carries words of two kinds. A load word (s_mode low)
// writes one Cb,Cr entry of the chroma plane and gives no result. A pixel word
// (s_mode high) carries luma and x,y and gives one RGB word on the m_ channel,
// flagged out_of_range with zero colors when it lies outside the frame.
// Frame width and height are set through the cfg_ write port while idle.
// The chroma plane sits in two parity banks of 32768 entries, each with two
// read ports, so the four neighbors of a pixel are read in the same cycle.
// A result passes the input, bank read, blend, product and output registers.
// Throughput: one word per cycle, load or pixel, sustained while m_ready is high.
// When the receiver stalls, the pipeline fills its empty stages and s_ready
// drops only when every stage holds a word.
// Reset clears the pipeline valids and sets width 1024 and height 512; the
// chroma plane is not cleared and needs no clearing pass.
module ycbcr_upsample_to_rgb_unit #(
    parameter int MAX_WIDTH  = ycu_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ycu_pkg::MAX_HEIGHT_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [ycu_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ycu_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_mode,
    input  ycu_pkg::addr_t                     s_chroma_addr,
    input  ycu_pkg::pix_t                      s_cb_value,
    input  ycu_pkg::pix_t                      s_cr_value,
    input  ycu_pkg::pix_t                      s_luma,
    input  logic [ycu_pkg::X_W-1:0]            s_pixel_x,
    input  logic [ycu_pkg::Y_W-1:0]            s_pixel_y,
    output logic                               m_valid,
    input  logic                               m_ready,
    output ycu_pkg::pix_t                      m_red,
    output ycu_pkg::pix_t                      m_green,
    output ycu_pkg::pix_t                      m_blue,
    output logic                               m_out_of_range
);

    localparam int ColsMax = MAX_WIDTH / 4;
    localparam int RowsMax = MAX_HEIGHT / 2;

    logic [ycu_pkg::FW_W-1:0] frame_width_reg, frame_width_next;
    logic [ycu_pkg::FH_W-1:0] frame_height_reg, frame_height_next;
    ycu_pkg::ccnt_t           cols, rows;

    ycu_pkg::ccnt_t cx0, cy0, cx_inc0, cy_inc0, cx_nb0, cy_nb0;
    logic           clamp_x0, clamp_y0, oor0;
    logic [2*ycu_pkg::CCOL_W-1:0] row_top0, row_bot0;

    logic rdy_out, rdy4, rdy3, rdy2, rdy1;
    logic p1_valid_reg, p1_valid_next;
    logic p2_valid_reg, p2_valid_next;
    logic p3_valid_reg, p3_valid_next;
    logic p4_valid_reg, p4_valid_next;
    logic out_valid_reg, out_valid_next;

    logic           p1_mode_reg, p1_oor_reg, p1_clamp_reg, p1_sub_y_reg;
    logic [1:0]     p1_sub_x_reg;
    ycu_pkg::addr_t p1_row_top_reg, p1_row_bot_reg, p1_ld_addr_reg;
    ycu_pkg::ccnt_t p1_col_reg, p1_col_nb_reg;
    ycu_pkg::pix_t  p1_luma_reg;
    ycu_pkg::entry_t p1_ld_data_reg;

    ycu_pkg::addr_t       a_tl, a_tr, a_bl, a_br;
    ycu_pkg::interp_ctl_t ctl1;
    ycu_pkg::baddr_t      even_top_addr, odd_top_addr, even_bot_addr, odd_bot_addr;
    logic                 wr_en;

    ycu_pkg::interp_ctl_t p2_ctl_reg;
    ycu_pkg::pix_t        p2_luma_reg, p3_luma_reg;
    logic                 p2_oor_reg, p3_oor_reg;

    ycu_pkg::entry_t even_top, odd_top, even_bot, odd_bot;
    ycu_pkg::pix_t   cb3, cr3;

    always_comb begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_we) begin
            case (cfg_index)
                ycu_pkg::REG_FRAME_WIDTH: begin
                    frame_width_next = cfg_wdata;
                end
                ycu_pkg::REG_FRAME_HEIGHT: begin
                    frame_height_next = cfg_wdata[ycu_pkg::FH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= ycu_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= ycu_pkg::FRAME_HEIGHT_RST;
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    assign cols = (int'(frame_width_reg[ycu_pkg::FW_W-1:2]) > ColsMax)
                  ? ycu_pkg::ccnt_t'(ColsMax) : frame_width_reg[ycu_pkg::FW_W-1:2];
    assign rows = (int'(frame_height_reg[ycu_pkg::FH_W-1:1]) > RowsMax)
                  ? ycu_pkg::ccnt_t'(RowsMax) : frame_height_reg[ycu_pkg::FH_W-1:1];

    assign cx0      = {1'b0, s_pixel_x[ycu_pkg::X_W-1:2]};
    assign cy0      = {1'b0, s_pixel_y[ycu_pkg::Y_W-1:1]};
    assign cx_inc0  = cx0 + ycu_pkg::ccnt_t'(1);
    assign cy_inc0  = cy0 + ycu_pkg::ccnt_t'(1);
    assign clamp_x0 = (cx_inc0 == cols);
    assign clamp_y0 = (cy_inc0 == rows);
    assign cx_nb0   = clamp_x0 ? cx0 : cx_inc0;
    assign cy_nb0   = clamp_y0 ? cy0 : cy_inc0;
    assign oor0     = (cx0 >= cols) || (cy0 >= rows);
    assign row_top0 = {{ycu_pkg::CCOL_W{1'b0}}, cy0} * {{ycu_pkg::CCOL_W{1'b0}}, cols};
    assign row_bot0 = {{ycu_pkg::CCOL_W{1'b0}}, cy_nb0} * {{ycu_pkg::CCOL_W{1'b0}}, cols};

    assign rdy_out = !out_valid_reg || m_ready;
    assign rdy4    = !p4_valid_reg || rdy_out;
    assign rdy3    = !p3_valid_reg || rdy4;
    assign rdy2    = !p2_valid_reg || rdy3;
    assign rdy1    = !p1_valid_reg || rdy2;
    assign s_ready = rdy1;

    always_comb begin
        p1_valid_next  = rdy1 ? s_valid : p1_valid_reg;
        p2_valid_next  = rdy2 ? (p1_valid_reg && (p1_mode_reg == ycu_pkg::MODE_PIXEL))
                              : p2_valid_reg;
        p3_valid_next  = rdy3 ? p2_valid_reg : p3_valid_reg;
        p4_valid_next  = rdy4 ? p3_valid_reg : p4_valid_reg;
        out_valid_next = rdy_out ? p4_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p2_valid_next;
            p3_valid_reg  <= p3_valid_next;
            p4_valid_reg  <= p4_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            p1_mode_reg    <= s_mode;
            p1_oor_reg     <= oor0;
            p1_clamp_reg   <= clamp_x0;
            p1_sub_x_reg   <= s_pixel_x[1:0];
            p1_sub_y_reg   <= s_pixel_y[0];
            p1_row_top_reg <= row_top0[ycu_pkg::ADDR_W-1:0];
            p1_row_bot_reg <= row_bot0[ycu_pkg::ADDR_W-1:0];
            p1_col_reg     <= cx0;
            p1_col_nb_reg  <= cx_nb0;
            p1_luma_reg    <= s_luma;
            p1_ld_addr_reg <= s_chroma_addr;
            p1_ld_data_reg <= {s_cr_value, s_cb_value};
        end
    end

    assign a_tl = p1_row_top_reg + ycu_pkg::addr_t'(p1_col_reg);
    assign a_tr = p1_row_top_reg + ycu_pkg::addr_t'(p1_col_nb_reg);
    assign a_bl = p1_row_bot_reg + ycu_pkg::addr_t'(p1_col_reg);
    assign a_br = p1_row_bot_reg + ycu_pkg::addr_t'(p1_col_nb_reg);

    always_comb begin
        ctl1.sel_top  = a_tl[0];
        ctl1.sel_bot  = a_bl[0];
        ctl1.clamp_x  = p1_clamp_reg;
        ctl1.sub_x    = p1_sub_x_reg;
        ctl1.sub_y    = p1_sub_y_reg;
        even_top_addr = a_tl[0] ? a_tr[ycu_pkg::ADDR_W-1:1] : a_tl[ycu_pkg::ADDR_W-1:1];
        odd_top_addr  = a_tl[0] ? a_tl[ycu_pkg::ADDR_W-1:1] : a_tr[ycu_pkg::ADDR_W-1:1];
        even_bot_addr = a_bl[0] ? a_br[ycu_pkg::ADDR_W-1:1] : a_bl[ycu_pkg::ADDR_W-1:1];
        odd_bot_addr  = a_bl[0] ? a_bl[ycu_pkg::ADDR_W-1:1] : a_br[ycu_pkg::ADDR_W-1:1];
    end

    assign wr_en = p1_valid_reg && (p1_mode_reg == ycu_pkg::MODE_LOAD) && rdy2;

    ycu_bank u_bank_even (
        .aclk    (aclk),
        .we      (wr_en && !p1_ld_addr_reg[0]),
        .waddr   (p1_ld_addr_reg[ycu_pkg::ADDR_W-1:1]),
        .wdata   (p1_ld_data_reg),
        .re      (rdy2),
        .raddr_a (even_top_addr),
        .raddr_b (even_bot_addr),
        .rdata_a (even_top),
        .rdata_b (even_bot)
    );

    ycu_bank u_bank_odd (
        .aclk    (aclk),
        .we      (wr_en && p1_ld_addr_reg[0]),
        .waddr   (p1_ld_addr_reg[ycu_pkg::ADDR_W-1:1]),
        .wdata   (p1_ld_data_reg),
        .re      (rdy2),
        .raddr_a (odd_top_addr),
        .raddr_b (odd_bot_addr),
        .rdata_a (odd_top),
        .rdata_b (odd_bot)
    );

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            p2_ctl_reg  <= ctl1;
            p2_luma_reg <= p1_luma_reg;
            p2_oor_reg  <= p1_oor_reg;
        end
        if (rdy3) begin
            p3_luma_reg <= p2_luma_reg;
            p3_oor_reg  <= p2_oor_reg;
        end
    end

    ycu_interp u_interp (
        .aclk     (aclk),
        .en       (rdy3),
        .ctl      (p2_ctl_reg),
        .even_top (even_top),
        .odd_top  (odd_top),
        .even_bot (even_bot),
        .odd_bot  (odd_bot),
        .cb       (cb3),
        .cr       (cr3)
    );

    ycu_csc u_csc (
        .aclk         (aclk),
        .en_prod      (rdy4),
        .en_out       (rdy_out),
        .luma         (p3_luma_reg),
        .cb           (cb3),
        .cr           (cr3),
        .oor          (p3_oor_reg),
        .red          (m_red),
        .green        (m_green),
        .blue         (m_blue),
        .out_of_range (m_out_of_range)
    );

    assign m_valid = out_valid_reg;

endmodule

[tb/ycu_rgb_checker.sv]
// Watches both channels of the YCbCr upsampler, predicts each RGB word and compares it.
module ycu_rgb_checker #(
    parameter int MAX_WIDTH  = ycu_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ycu_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [ycu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ycu_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_mode,
    input  ycu_pkg::addr_t                  s_chroma_addr,
    input  ycu_pkg::pix_t                   s_cb_value,
    input  ycu_pkg::pix_t                   s_cr_value,
    input  ycu_pkg::pix_t                   s_luma,
    input  logic [ycu_pkg::X_W-1:0]         s_pixel_x,
    input  logic [ycu_pkg::Y_W-1:0]         s_pixel_y,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  ycu_pkg::pix_t                   m_red,
    input  ycu_pkg::pix_t                   m_green,
    input  ycu_pkg::pix_t                   m_blue,
    input  logic                            m_out_of_range,
    output int                              rgb_outstanding,
    output int                              mismatch_count
);

    localparam longint LUMA_GAIN   = 76309;
    localparam longint CR_TO_RED   = 104597;
    localparam longint CB_TO_GREEN = 25674;
    localparam longint CR_TO_GREEN = 53279;
    localparam longint CB_TO_BLUE  = 132201;
    localparam longint RED_BIAS    = 14609351;
    localparam longint GREEN_BIAS  = 8885109;
    localparam longint BLUE_BIAS   = 18142724;

    typedef struct packed {
        ycu_pkg::pix_t red;
        ycu_pkg::pix_t green;
        ycu_pkg::pix_t blue;
        logic          outside;
    } rgb_word_t;

    bit [15:0]    chroma_copy [65536];
    logic [10:0]  width_reg  = 11'd1024;
    logic [9:0]   height_reg = 10'd512;
    rgb_word_t    rgb_expected [$];
    rgb_word_t    got;
    rgb_word_t    want;
    int           fail_tally    = 0;
    int           pending_words = 0;

    assign rgb_outstanding = pending_words;
    assign mismatch_count  = fail_tally;

    function automatic ycu_pkg::pix_t sat_byte(input longint acc);
        longint q;
        if (acc < 0)
            return '0;
        q = acc >>> 16;
        return (q > 255) ? ycu_pkg::pix_t'(255) : ycu_pkg::pix_t'(q);
    endfunction

    function automatic rgb_word_t predict_rgb(input ycu_pkg::pix_t luma,
                                              input logic [ycu_pkg::X_W-1:0] px,
                                              input logic [ycu_pkg::Y_W-1:0] py);
        int unsigned w, h, cw, ch, cx, cy, cx1, cy1, sx, ty;
        int unsigned w00, w01, w10, w11, cb, cr;
        bit [15:0]   e00, e01, e10, e11;
        longint      yl, r, g, b;
        rgb_word_t   res;
        res = '0;
        w = {width_reg[10:2], 2'b00};
        if (w > MAX_WIDTH)
            w = MAX_WIDTH & ~3;
        h = {height_reg[9:1], 1'b0};
        if (h > MAX_HEIGHT)
            h = MAX_HEIGHT & ~1;
        if (px >= w || py >= h) begin
            res.outside = 1'b1;
            return res;
        end
        cw  = w / 4;
        ch  = h / 2;
        cx  = px / 4;
        cy  = py / 2;
        cx1 = (cx + 1 < cw) ? cx + 1 : cw - 1;
        cy1 = (cy + 1 < ch) ? cy + 1 : ch - 1;
        sx  = px[1:0];
        ty  = py[0];
        e00 = chroma_copy[(cy * cw + cx) & 32'hFFFF];
        e01 = chroma_copy[(cy * cw + cx1) & 32'hFFFF];
        e10 = chroma_copy[(cy1 * cw + cx) & 32'hFFFF];
        e11 = chroma_copy[(cy1 * cw + cx1) & 32'hFFFF];
        w00 = (4 - sx) * (2 - ty);
        w01 = sx * (2 - ty);
        w10 = (4 - sx) * ty;
        w11 = sx * ty;
        cb = (e00[7:0] * w00 + e01[7:0] * w01 + e10[7:0] * w10 + e11[7:0] * w11) / 8;
        cr = (e00[15:8] * w00 + e01[15:8] * w01 + e10[15:8] * w10 + e11[15:8] * w11) / 8;
        yl = LUMA_GAIN * longint'(luma);
        r  = yl + CR_TO_RED * longint'(cr) - RED_BIAS;
        g  = yl - CB_TO_GREEN * longint'(cb) - CR_TO_GREEN * longint'(cr) + GREEN_BIAS;
        b  = yl + CB_TO_BLUE * longint'(cb) - BLUE_BIAS;
        res.red   = sat_byte(r);
        res.green = sat_byte(g);
        res.blue  = sat_byte(b);
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = 11'd1024;
            height_reg = 10'd512;
            rgb_expected.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = '{red: m_red, green: m_green, blue: m_blue, outside: m_out_of_range};
                if (rgb_expected.size() == 0) begin
                    if (fail_tally < 10)
                        $display("Unexpected RGB word at %0t: r=%0d g=%0d b=%0d oor=%0b",
                                 $time, got.red, got.green, got.blue, got.outside);
                    fail_tally++;
                end else begin
                    want = rgb_expected.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.outside !== want.outside) begin
                        if (fail_tally < 10) begin
                            $display("RGB mismatch at %0t: expected r=%0d g=%0d b=%0d oor=%0b",
                                     $time, want.red, want.green, want.blue, want.outside);
                            $display("    got r=%0d g=%0d b=%0d oor=%0b",
                                     got.red, got.green, got.blue, got.outside);
                        end
                        fail_tally++;
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_index == ycu_pkg::REG_FRAME_WIDTH)
                    width_reg = cfg_wdata[10:0];
                else if (cfg_index == ycu_pkg::REG_FRAME_HEIGHT)
                    height_reg = cfg_wdata[9:0];
            end
            if (s_valid && s_ready) begin
                if (s_mode == ycu_pkg::MODE_LOAD)
                    chroma_copy[s_chroma_addr] = {s_cr_value, s_cb_value};
                else
                    rgb_expected.push_back(predict_rgb(s_luma, s_pixel_x, s_pixel_y));
            end
        end
        pending_words <= rgb_expected.size();
    end

endmodule

[tb/ycbcr_upsample_to_rgb_unit_test.sv]
// Testbench top for the YCbCr upsampler: clock, reset, stimulus, pacing and verdict.
module ycbcr_upsample_to_rgb_unit_test;

    typedef logic [ycu_pkg::CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [ycu_pkg::CFG_DATA_W-1:0]  cfg_data_t;
    typedef logic [ycu_pkg::X_W-1:0]         px_t;
    typedef logic [ycu_pkg::Y_W-1:0]         py_t;

    localparam int FRAME_MAX_W     = 1024;
    localparam int FRAME_MAX_H     = 512;
    localparam int PIPE_SETTLE     = 10;
    localparam int PHASES          = 8;
    localparam int STEPS_PER_PHASE = 40;

    localparam cfg_index_t REG_SPARE_2 = 2'd2;
    localparam cfg_index_t REG_SPARE_3 = 2'd3;

    logic                   aclk           = 1'b0;
    logic                   aresetn        = 1'b0;
    logic                   cfg_we         = 1'b0;
    cfg_index_t             cfg_index      = ycu_pkg::REG_FRAME_WIDTH;
    cfg_data_t              cfg_wdata      = '0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic                   s_mode         = ycu_pkg::MODE_LOAD;
    ycu_pkg::addr_t         s_chroma_addr  = '0;
    ycu_pkg::pix_t          s_cb_value     = '0;
    ycu_pkg::pix_t          s_cr_value     = '0;
    ycu_pkg::pix_t          s_luma         = '0;
    px_t                    s_pixel_x      = '0;
    py_t                    s_pixel_y      = '0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    ycu_pkg::pix_t          m_red;
    ycu_pkg::pix_t          m_green;
    ycu_pkg::pix_t          m_blue;
    logic                   m_out_of_range;

    int          rgb_outstanding;
    int          mismatch_count;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned eff_w         = FRAME_MAX_W;
    int unsigned eff_h         = FRAME_MAX_H;
    bit          chroma_written [65536];
    int          n_loads       = 0;
    int          n_pixels      = 0;
    int          n_outside     = 0;
    int          n_settings    = 0;

    cfg_data_t width_plan  [PHASES] = '{11'd16, 11'd2047, 11'd4, 11'd1023,
                                        11'd40, 11'd0, 11'd1024, 11'd130};
    cfg_data_t height_plan [PHASES] = '{11'd4, 11'h7FF, 11'd2, 11'h5FF,
                                        11'd12, 11'd1, 11'd512, 11'd7};

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    ycbcr_upsample_to_rgb_unit #(
        .MAX_WIDTH  (FRAME_MAX_W),
        .MAX_HEIGHT (FRAME_MAX_H)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_chroma_addr  (s_chroma_addr),
        .s_cb_value     (s_cb_value),
        .s_cr_value     (s_cr_value),
        .s_luma         (s_luma),
        .s_pixel_x      (s_pixel_x),
        .s_pixel_y      (s_pixel_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_out_of_range (m_out_of_range)
    );

    ycu_rgb_checker #(
        .MAX_WIDTH  (FRAME_MAX_W),
        .MAX_HEIGHT (FRAME_MAX_H)
    ) rgb_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_chroma_addr   (s_chroma_addr),
        .s_cb_value      (s_cb_value),
        .s_cr_value      (s_cr_value),
        .s_luma          (s_luma),
        .s_pixel_x       (s_pixel_x),
        .s_pixel_y       (s_pixel_y),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red           (m_red),
        .m_green         (m_green),
        .m_blue          (m_blue),
        .m_out_of_range  (m_out_of_range),
        .rgb_outstanding (rgb_outstanding),
        .mismatch_count  (mismatch_count)
    );

    task automatic send_word(input logic mode, input ycu_pkg::addr_t addr,
                             input ycu_pkg::pix_t cb, input ycu_pkg::pix_t cr,
                             input ycu_pkg::pix_t luma, input px_t px, input py_t py);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= mode;
        s_chroma_addr <= addr;
        s_cb_value    <= cb;
        s_cr_value    <= cr;
        s_luma        <= luma;
        s_pixel_x     <= px;
        s_pixel_y     <= py;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic load_entry(input ycu_pkg::addr_t addr, input ycu_pkg::pix_t cb,
                              input ycu_pkg::pix_t cr);
        send_word(ycu_pkg::MODE_LOAD, addr, cb, cr, ycu_pkg::pix_t'($urandom),
                  px_t'($urandom), py_t'($urandom));
        chroma_written[addr] = 1'b1;
        n_loads++;
    endtask

    task automatic convert_pixel(input px_t px, input py_t py, input ycu_pkg::pix_t luma);
        int unsigned    cw, ch, cx, cy, cx1, cy1;
        ycu_pkg::addr_t nb [4];
        if (px < eff_w && py < eff_h) begin
            cw    = eff_w / 4;
            ch    = eff_h / 2;
            cx    = px / 4;
            cy    = py / 2;
            cx1   = (cx + 1 < cw) ? cx + 1 : cw - 1;
            cy1   = (cy + 1 < ch) ? cy + 1 : ch - 1;
            nb[0] = ycu_pkg::addr_t'(cy * cw + cx);
            nb[1] = ycu_pkg::addr_t'(cy * cw + cx1);
            nb[2] = ycu_pkg::addr_t'(cy1 * cw + cx);
            nb[3] = ycu_pkg::addr_t'(cy1 * cw + cx1);
            // fill any neighbor not yet written
            foreach (nb[i])
                if (!chroma_written[nb[i]])
                    load_entry(nb[i], ycu_pkg::pix_t'($urandom), ycu_pkg::pix_t'($urandom));
            n_pixels++;
        end else begin
            n_outside++;
        end
        send_word(ycu_pkg::MODE_PIXEL, ycu_pkg::addr_t'($urandom), ycu_pkg::pix_t'($urandom),
                  ycu_pkg::pix_t'($urandom), luma, px, py);
    endtask

    task automatic write_reg(input cfg_index_t idx, input cfg_data_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic set_frame(input cfg_data_t wreg, input cfg_data_t hreg);
        write_reg(ycu_pkg::REG_FRAME_WIDTH, wreg);
        write_reg(ycu_pkg::REG_FRAME_HEIGHT, hreg);
        write_reg(($urandom_range(1) != 0) ? REG_SPARE_2 : REG_SPARE_3,
                  cfg_data_t'($urandom));
        cfg_we <= 1'b0;
        eff_w = {wreg[10:2], 2'b00};
        if (eff_w > FRAME_MAX_W)
            eff_w = FRAME_MAX_W;
        eff_h = {hreg[9:1], 1'b0};
        if (eff_h > FRAME_MAX_H)
            eff_h = FRAME_MAX_H;
        n_settings++;
    endtask

    task automatic drain_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (rgb_outstanding != 0) @(posedge aclk);
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    task automatic random_step();
        int unsigned   plane;
        px_t           px;
        py_t           py;
        ycu_pkg::pix_t luma;
        plane = (eff_w / 4) * (eff_h / 2);
        if ($urandom_range(3) == 0) begin
            if (plane != 0 && $urandom_range(1) == 0)
                load_entry(ycu_pkg::addr_t'($urandom_range(plane - 1)),
                           ycu_pkg::pix_t'($urandom), ycu_pkg::pix_t'($urandom));
            else
                load_entry(ycu_pkg::addr_t'($urandom), ycu_pkg::pix_t'($urandom),
                           ycu_pkg::pix_t'($urandom));
        end else begin
            if (eff_w != 0 && eff_h != 0 && $urandom_range(9) < 8) begin
                px = px_t'($urandom_range(eff_w - 1));
                py = py_t'($urandom_range(eff_h - 1));
                // lean on the right and bottom edges
                if ($urandom_range(7) == 0)
                    px = px_t'(eff_w - 1 - $urandom_range(3));
                if ($urandom_range(7) == 0)
                    py = py_t'(eff_h - 1 - $urandom_range(1));
            end else begin
                px = px_t'($urandom);
                py = py_t'($urandom);
            end
            case ($urandom_range(7))
                0: luma = '0;
                1: luma = '1;
                default: luma = ycu_pkg::pix_t'($urandom);
            endcase
            convert_pixel(px, py, luma);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_entry(16'h0000, 8'h00, 8'hFF);
        load_entry(16'h0001, 8'hFF, 8'h00);
        load_entry(16'h0100, 8'hFF, 8'hFF);
        load_entry(16'h0101, 8'h00, 8'h00);
        convert_pixel(10'd0, 9'd0, 8'h00);
        convert_pixel(10'd0, 9'd0, 8'hFF);
        convert_pixel(10'd3, 9'd1, 8'hFF);
        convert_pixel(10'd2, 9'd1, 8'h10);
        convert_pixel(10'd5, 9'd0, 8'hEB);
        load_entry(16'hFFFF, 8'hFF, 8'h00);
        convert_pixel(10'h3FF, 9'h1FF, 8'hFF);
        convert_pixel(10'h3FC, 9'h1FE, 8'h00);
        drain_idle();
        set_frame(11'd7, 11'd3);
        convert_pixel(10'd3, 9'd1, 8'h50);
        convert_pixel(10'd4, 9'd0, 8'hFF);
        convert_pixel(10'd0, 9'd2, 8'hFF);
        drain_idle();
        set_frame(11'h7FF, 11'h7FF);
        convert_pixel(10'h3FF, 9'h1FF, 8'h80);
        convert_pixel(10'd512, 9'd256, 8'h80);
        drain_idle();
        set_frame(11'd3, 11'd1);
        convert_pixel(10'd0, 9'd0, 8'h80);

        for (int p = 0; p < PHASES; p++) begin
            drain_idle();
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 76;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 76;
                end
                default: begin
                    send_idle_pct = 9;
                    stall_pct     = 9;
                end
            endcase
            set_frame(width_plan[p], height_plan[p]);
            repeat (STEPS_PER_PHASE) random_step();
        end
        drain_idle();

        $display("Run covered %0d chroma loads, %0d pixels inside and %0d outside the frame",
                 n_loads, n_pixels, n_outside);
        $display("over %0d frame settings, with free-running, sender-idle, receiver-stall %s",
                 n_settings, "and mixed pacing.");
        if (mismatch_count == 0 && rgb_outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

[ycbcr_upsample_to_rgb_unit.f]
sv/ycu_pkg.sv
sv/ycu_bank.sv
sv/ycu_interp.sv
sv/ycu_csc.sv
sv/ycbcr_upsample_to_rgb_unit.sv
tb/ycu_rgb_checker.sv
tb/ycbcr_upsample_to_rgb_unit_test.sv
